// ----- hdl/ccc_pkg.sv -----
`timescale 1ns / 1ps
package ccc_pkg;

  localparam int MAX_DIM     = 16;
  localparam int DIM_LIMIT   = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int EDGE_W      = 16;
  localparam int CYC_W       = 4;
  localparam int DIM_W       = 5;
  localparam int HOP_W       = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd8;

  // One classified request as it waits between front and back.
  typedef struct packed {
    logic              bad;
    logic [EDGE_W-1:0] start_edge;
    logic [CYC_W-1:0]  start_cycle;
    logic [EDGE_W-1:0] diff;
    logic [DIM_W-1:0]  dim;
    logic              sweep_up;
    logic              walk_up;
    logic [CYC_W-1:0]  walk_len;
  } route_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_FLIP,
    BK_MOVE
  } back_state_t;

  // One step around the cycle, wrapping at the dimension.
  function automatic logic [CYC_W-1:0] step_cycle(input logic [CYC_W-1:0] c,
                                                  input logic up,
                                                  input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] inc;
    logic [DIM_W-1:0] top;
    inc = {1'b0, c} + DIM_W'(1);
    top = d - DIM_W'(1);
    if (up) begin
      step_cycle = (inc >= d) ? '0 : inc[CYC_W-1:0];
    end else begin
      step_cycle = (c == '0) ? top[CYC_W-1:0] : c - CYC_W'(1);
    end
  endfunction

endpackage

// ----- hdl/ccc_front.sv -----
`timescale 1ns / 1ps
module ccc_front (
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [ccc_pkg::EDGE_W-1:0]   start_edge,
  input  logic [ccc_pkg::CYC_W-1:0]    start_cycle,
  input  logic [ccc_pkg::EDGE_W-1:0]   end_edge,
  input  logic [ccc_pkg::CYC_W-1:0]    end_cycle,
  input  logic [ccc_pkg::DIM_W-1:0]    dim,
  input  logic                         full,
  output logic                         push,
  output ccc_pkg::route_t              entry
);
  import ccc_pkg::*;

  logic [DIM_W:0]   fwd_raw;
  logic [DIM_W:0]   back_raw;
  logic [DIM_W:0]   fwd;
  logic [DIM_W:0]   back;
  logic [DIM_W:0]   near;
  logic             sweep_up;

  assign req_stall = full;
  assign push      = req_valid && !full;

  always_comb begin
    // distances around the cycle; both raw sums stay below twice the dimension
    fwd_raw  = {2'b00, end_cycle} + {1'b0, dim} - {2'b00, start_cycle};
    back_raw = {2'b00, start_cycle} + {1'b0, dim} - {2'b00, end_cycle};
    fwd      = (fwd_raw >= {1'b0, dim}) ? fwd_raw - {1'b0, dim} : fwd_raw;
    back     = (back_raw >= {1'b0, dim}) ? back_raw - {1'b0, dim} : back_raw;
    sweep_up = !(fwd < back);
    near     = (fwd > back) ? back : fwd;

    entry.bad = (dim < DIM_W'(2)) || (dim > DIM_W'(DIM_LIMIT)) ||
                ({1'b0, start_cycle} >= dim) || ({1'b0, end_cycle} >= dim);
    entry.start_edge  = start_edge;
    entry.start_cycle = start_cycle;
    entry.diff        = start_edge ^ end_edge;
    entry.dim         = dim;
    entry.sweep_up    = sweep_up;
    // equal positions: one step along the sweep; otherwise walk back
    if (near == '0) begin
      entry.walk_up  = sweep_up;
      entry.walk_len = CYC_W'(1);
    end else begin
      entry.walk_up  = !sweep_up;
      entry.walk_len = CYC_W'(near - (DIM_W+1)'(1));
    end
  end

endmodule

// ----- hdl/ccc_queue.sv -----
`timescale 1ns / 1ps
module ccc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ccc_pkg::route_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output ccc_pkg::route_t  head
);
  import ccc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  route_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hdl/ccc_back.sv -----
`timescale 1ns / 1ps
module ccc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_avail,
  input  ccc_pkg::route_t             q_head,
  output logic                        q_pop,
  output logic                        node_valid,
  input  logic                        node_stall,
  output logic [ccc_pkg::EDGE_W-1:0]  node_edge,
  output logic [ccc_pkg::CYC_W-1:0]   node_cycle,
  output logic [ccc_pkg::HOP_W-1:0]   hop_count,
  output logic                        last,
  output logic                        bad_input
);
  import ccc_pkg::*;

  back_state_t        state, state_next;
  route_t             ctx, ctx_next;
  logic [EDGE_W-1:0]  cur_e, cur_e_next;
  logic [CYC_W-1:0]   cur_c, cur_c_next;
  logic [HOP_W-1:0]   hops, hops_next;
  logic [CYC_W-1:0]   sweep_left, sweep_left_next;
  logic [CYC_W-1:0]   walk_left, walk_left_next;

  logic               ld;
  logic               emit;
  logic [EDGE_W-1:0]  em_e;
  logic [CYC_W-1:0]   em_c;
  logic [HOP_W-1:0]   em_h;
  logic               em_last;
  logic               em_bad;
  logic [CYC_W-1:0]   c_step;

  // output register is free when empty or being taken
  assign ld = !node_valid || !node_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    ctx_next        = ctx;
    cur_e_next      = cur_e;
    cur_c_next      = cur_c;
    hops_next       = hops;
    sweep_left_next = sweep_left;
    walk_left_next  = walk_left;
    q_pop           = 1'b0;
    emit            = 1'b0;
    em_e            = cur_e;
    em_c            = cur_c;
    em_h            = hops;
    em_last         = 1'b0;
    em_bad          = 1'b0;
    c_step          = step_cycle(cur_c, (sweep_left != '0) ? ctx.sweep_up : ctx.walk_up,
                                 ctx.dim);
    case (state)
      BK_IDLE: begin
        q_pop = q_avail;
        if (q_avail) begin
          ctx_next        = q_head;
          cur_e_next      = q_head.start_edge;
          cur_c_next      = q_head.start_cycle;
          hops_next       = '0;
          sweep_left_next = CYC_W'(q_head.dim - DIM_W'(1));
          walk_left_next  = q_head.walk_len;
          state_next      = BK_START;
        end
      end
      BK_START: begin
        if (ld) begin
          emit = 1'b1;
          if (ctx.bad) begin
            em_e       = '0;
            em_c       = '0;
            em_h       = '0;
            em_last    = 1'b1;
            em_bad     = 1'b1;
            state_next = BK_IDLE;
          end else begin
            state_next = ctx.diff[cur_c] ? BK_FLIP : BK_MOVE;
          end
        end
      end
      BK_FLIP: begin
        if (ld) begin
          emit       = 1'b1;
          cur_e_next = cur_e ^ (EDGE_W'(1) << cur_c);
          hops_next  = hops + HOP_W'(1);
          em_e       = cur_e_next;
          em_h       = hops_next;
          em_last    = (sweep_left == '0) && (walk_left == '0);
          state_next = em_last ? BK_IDLE : BK_MOVE;
        end
      end
      BK_MOVE: begin
        if (ld) begin
          emit       = 1'b1;
          cur_c_next = c_step;
          hops_next  = hops + HOP_W'(1);
          em_c       = c_step;
          em_h       = hops_next;
          if (sweep_left != '0) begin
            sweep_left_next = sweep_left - CYC_W'(1);
            em_last = !ctx.diff[c_step] && (sweep_left_next == '0) && (walk_left == '0);
            if (em_last) begin
              state_next = BK_IDLE;
            end else begin
              state_next = ctx.diff[c_step] ? BK_FLIP : BK_MOVE;
            end
          end else begin
            walk_left_next = walk_left - CYC_W'(1);
            em_last        = (walk_left_next == '0);
            state_next     = em_last ? BK_IDLE : BK_MOVE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ctx        <= ctx_next;
    cur_e      <= cur_e_next;
    cur_c      <= cur_c_next;
    hops       <= hops_next;
    sweep_left <= sweep_left_next;
    walk_left  <= walk_left_next;
    if (emit) begin
      node_edge  <= em_e;
      node_cycle <= em_c;
      hop_count  <= em_h;
      last       <= em_last;
      bad_input  <= em_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= 1'b0;
    end else if (ld) begin
      node_valid <= emit;
    end
  end

  a_bad_is_single : assert property (@(posedge clk) disable iff (rst)
    node_valid && bad_input |-> last && (hop_count == '0) && (node_edge == '0))
    else $error("error result not a lone zeroed final node");

  a_walk_left : assert property (@(posedge clk) disable iff (rst)
    (state == BK_MOVE) && (sweep_left == '0) |-> (walk_left != '0))
    else $error("move phase with nothing left to emit");

  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    emit && em_last |=> (state == BK_IDLE))
    else $error("sequencer kept running after the final node");

  a_no_pop_busy : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_IDLE) && q_avail)
    else $error("request popped while a route is in progress");

endmodule

// ----- hdl/cube_connected_cycles_route_walk.sv -----
`timescale 1ns / 1ps
// Cube-connected-cycles route walk.
// A request (start_edge, start_cycle, end_edge, end_cycle) enters on the
// req channel when req_valid is high and req_stall is low. The block answers
// with every node of the route, one per node channel transfer (node_valid
// high, node_stall low); the final node carries last. A cycle position not
// below the dimension, or a dimension outside the supported range, gives a
// single zeroed node with bad_input and last set.
// The dimension register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Flow: a classifier takes requests into a two-entry queue without waiting
// on the walk; the sequencer pops one request and loads it, then emits one
// node per cycle while node_stall is low: 1 + (dimension-1) moves + one per
// differing cube bit + the walk back, at most 39 nodes. A request passes
// through the queue, the sequencer load and the output register before its
// first node appears. When node_stall is high the output register and the
// sequencer hold; the queue keeps taking requests until full, then
// req_stall rises. Reset clears the queue, the sequencer and node_valid, and
// sets the dimension to 8.
module cube_connected_cycles_route_walk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ccc_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [ccc_pkg::EDGE_W-1:0]  start_edge,
  input  logic [ccc_pkg::CYC_W-1:0]   start_cycle,
  input  logic [ccc_pkg::EDGE_W-1:0]  end_edge,
  input  logic [ccc_pkg::CYC_W-1:0]   end_cycle,
  output logic                        node_valid,
  input  logic                        node_stall,
  output logic [ccc_pkg::EDGE_W-1:0]  node_edge,
  output logic [ccc_pkg::CYC_W-1:0]   node_cycle,
  output logic [ccc_pkg::HOP_W-1:0]   hop_count,
  output logic                        last,
  output logic                        bad_input
);
  import ccc_pkg::*;

  logic [DIM_W-1:0] dimension;
  logic             full;
  logic             push;
  route_t           entry;
  logic             q_avail;
  logic             q_pop;
  route_t           q_head;

  // dimension register; the user must write it only while no route is in flight; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_we) begin
      dimension <= cfg_wdata;
    end
  end

  // classify: range check, difference word, sweep and walk-back direction
  ccc_front u_front (
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .start_edge  (start_edge),
    .start_cycle (start_cycle),
    .end_edge    (end_edge),
    .end_cycle   (end_cycle),
    .dim         (dimension),
    .full        (full),
    .push        (push),
    .entry       (entry)
  );

  // decouple the classifier from the node sequencer
  ccc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .full       (full),
    .pop        (q_pop),
    .avail      (q_avail),
    .head       (q_head)
  );

  // emit route nodes one per cycle into the output register while node_stall is low
  ccc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .node_valid (node_valid),
    .node_stall (node_stall),
    .node_edge  (node_edge),
    .node_cycle (node_cycle),
    .hop_count  (hop_count),
    .last       (last),
    .bad_input  (bad_input)
  );

endmodule
